@@ hw/rtl/spc_pkg.sv @@
// Shared types, register codes and constants of the spectral palette color unit.
package spc_pkg;

  localparam int DEF_INDEX_BITS = 12;
  localparam int DEF_COS_TABLE_DEPTH = 1024;

  localparam int CFG_W = 13;

  localparam logic [CFG_W-1:0] COLOR_COUNT_RESET = 13'd256;
  localparam logic [CFG_W-1:0] INTENSITY_FLOOR_RESET = 13'd1024;

  localparam logic CFG_COLOR_COUNT = 1'b0;
  localparam logic CFG_INTENSITY_FLOOR = 1'b1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [27:0] INV_2SQRT3_Q14 = 28'd4730;
  localparam logic [14:0] Q14_ONE = 15'd16384;
  localparam logic [14:0] Q14_HALF = 15'd8192;

  typedef enum logic [1:0] {
    KIND_BLACK,
    KIND_WHITE,
    KIND_THREE,
    KIND_NORMAL
  } kind_t;

  typedef enum logic [1:0] {
    SEC_RG,
    SEC_GB,
    SEC_BR
  } sector_t;

endpackage

@@ hw/rtl/spc_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage, with a sideband tag.
module spc_div_pipe #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] out_tag
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [TW-1:0] tag_r [QW];
  logic          vld_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [TW-1:0] tag_in;
    logic          vld_in;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          qbit;

    if (s == 0) begin : g_first
      assign rem_in = DW'(num >> QW);
      assign low_in = num[QW-1:0];
      assign den_in = den;
      assign tag_in = tag;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign den_in = den_r[s-1];
      assign tag_in = tag_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    assign shifted = {rem_in, low_in[QW-1]};
    assign qbit = shifted >= {1'b0, den_in};
    assign diff = shifted - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= qbit ? diff[DW-1:0] : shifted[DW-1:0];
        low_r[s] <= (low_in << 1) | QW'(qbit);
        den_r[s] <= den_in;
        tag_r[s] <= tag_in;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quo = low_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule

@@ hw/rtl/spectral_palette_color_unit.sv @@
// Top level of the spectral palette color unit.
// Converts a palette index into the RGB of a black-blue-red-yellow-white spectral palette
// whose size and starting intensity come from two configuration registers. The unit is a
// fully pipelined datapath that takes one index per clock and delivers one color per clock
// while the output is not stalled. The four bit-per-stage dividers for intensity, table angle,
// tangent ratio and component scaling lie in series. A stalled output freezes the whole
// pipeline, so nothing is lost or repeated. The cosine table is a constant array read
// through a registered port.
module spectral_palette_color_unit #(
  parameter int INDEX_BITS = spc_pkg::DEF_INDEX_BITS,
  parameter int COS_TABLE_DEPTH = spc_pkg::DEF_COS_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [spc_pkg::CFG_W-1:0] cfg_data,
  input  logic                    color_valid,
  output logic                    color_stall,
  input  logic [INDEX_BITS-1:0]   color_index,
  output logic                    rgb_valid,
  input  logic                    rgb_stall,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue
);
  import spc_pkg::*;

  localparam int QJ = $clog2(COS_TABLE_DEPTH + 1);
  localparam int NJW = 16 + $clog2(COS_TABLE_DEPTH);

  function automatic logic [14:0] cos_q14(input int unsigned idx);
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] y;
    logic signed [63:0] r;
    one = 64'd1 << 30;
    x = (64'(idx) * HALF_PI_Q30 + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    y = one - x2 / 64'd90;
    y = one - ((y * x2) >> 30) / 64'd56;
    y = one - ((y * x2) >> 30) / 64'd30;
    y = one - ((y * x2) >> 30) / 64'd12;
    r = signed'(one) - signed'(((y * x2) >> 30) / 64'd2);
    if (r < 0) begin
      r = 0;
    end
    return 15'((64'(r) + 64'd32768) >> 16);
  endfunction

  logic [14:0] cos_rom [COS_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= COS_TABLE_DEPTH; gi++) begin : g_rom
    assign cos_rom[gi] = cos_q14(gi);
  end

  typedef struct packed {
    kind_t          kind;
    sector_t        sec;
    logic           neg;
    logic [NJW-1:0] nj;
    logic [15:0]    dj;
  } tag_i_t;

  typedef struct packed {
    kind_t       kind;
    sector_t     sec;
    logic        neg;
    logic [14:0] inten;
  } tag_j_t;

  typedef struct packed {
    kind_t       kind;
    sector_t     sec;
    logic        neg;
    logic [14:0] inten;
    logic        sat;
  } tag_u_t;

  typedef struct packed {
    kind_t       kind;
    sector_t     sec;
    logic        fb;
    logic [14:0] inten;
  } tag_v_t;

  logic [CFG_W-1:0] color_count;
  logic [CFG_W-1:0] intensity_floor;
  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count <= COLOR_COUNT_RESET;
      intensity_floor <= INTENSITY_FLOOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOR_COUNT: color_count <= cfg_data;
        CFG_INTENSITY_FLOOR: intensity_floor <= cfg_data;
      endcase
    end
  end

  assign en = !(rgb_valid && rgb_stall);
  assign color_stall = rgb_valid && rgb_stall;

  // Stage 1: classify the index.
  logic v1;
  kind_t k1;
  logic [12:0] m1, d1, fl1;
  kind_t kind_in;

  always_comb begin
    priority if (color_index == '0) begin
      kind_in = KIND_BLACK;
    end else if (17'(color_index) + 17'd1 >= 17'(color_count)) begin
      kind_in = KIND_WHITE;
    end else if (color_count == 13'd3) begin
      kind_in = KIND_THREE;
    end else begin
      kind_in = KIND_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= color_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1 <= kind_in;
      m1 <= 13'(color_index) - 13'd1;
      d1 <= color_count - 13'd3;
      fl1 <= intensity_floor;
    end
  end

  // Stage 2: raw hue position and intensity weights.
  logic v2;
  kind_t k2;
  logic [12:0] m2, d2, fl2, dm2;
  logic [15:0] f3_2, d6_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2 <= k1;
      m2 <= m1;
      d2 <= d1;
      fl2 <= fl1;
      dm2 <= d1 - m1;
      f3_2 <= 16'(m1) * 16'd3 + 16'(d1) * 16'd4;
      d6_2 <= 16'(d1) * 16'd6;
    end
  end

  // Stage 3: hue wrapped into one turn.
  logic v3;
  kind_t k3;
  logic [12:0] m3, d3;
  logic [15:0] f_3, d3x3, d5x3;
  logic [25:0] prod3;
  logic [15:0] fr;

  always_comb begin
    fr = (f3_2 >= d6_2) ? f3_2 - d6_2 : f3_2;
    if (fr == '0) begin
      fr = d6_2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k3 <= k2;
      m3 <= m2;
      d3 <= d2;
      f_3 <= fr;
      d3x3 <= 16'(d2) * 16'd3;
      d5x3 <= 16'(d2) * 16'd5;
      prod3 <= 26'(fl2) * 26'(dm2);
    end
  end

  // Stage 4: sector and offset from its center.
  logic v4;
  kind_t k4;
  sector_t sec4;
  logic neg4;
  logic [12:0] at4, d4;
  logic [26:0] num4;
  sector_t sec_c;
  logic [15:0] centre;

  always_comb begin
    if (f_3 <= (16'(d3) << 1)) begin
      sec_c = SEC_RG;
      centre = 16'(d3);
    end else if (f_3 <= (16'(d3) << 2)) begin
      sec_c = SEC_GB;
      centre = d3x3;
    end else begin
      sec_c = SEC_BR;
      centre = d5x3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k4 <= k3;
      sec4 <= sec_c;
      neg4 <= f_3 > centre;
      at4 <= (f_3 > centre) ? 13'(f_3 - centre) : 13'(centre - f_3);
      d4 <= d3;
      num4 <= 27'(prod3) + (27'(m3) << 12);
    end
  end

  // Stage 5: dividend and divisor for table angle and intensity.
  logic v5;
  tag_i_t ti5;
  logic [30:0] ni5;
  logic [13:0] di5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ti5.kind <= k4;
      ti5.sec <= sec4;
      ti5.neg <= neg4;
      ti5.nj <= NJW'(at4) * NJW'(4 * COS_TABLE_DEPTH) + NJW'(16'(d4) * 16'd3);
      ti5.dj <= 16'(d4) * 16'd6;
      ni5 <= (31'(num4) << 3) + 31'(d4);
      di5 <= 14'(d4) << 1;
    end
  end

  logic vi;
  logic [14:0] qi;
  tag_i_t tiq;

  spc_div_pipe #(
    .NW(31), .DW(14), .QW(15), .TW($bits(tag_i_t))
  ) u_div_inten (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v5), .num(ni5), .den(di5), .tag(ti5),
    .out_valid(vi), .quo(qi), .out_tag(tiq)
  );

  tag_j_t tj_in;
  logic vj;
  logic [QJ-1:0] qj;
  tag_j_t tjq;

  assign tj_in = '{kind: tiq.kind, sec: tiq.sec, neg: tiq.neg, inten: qi};

  spc_div_pipe #(
    .NW(NJW), .DW(16), .QW(QJ), .TW($bits(tag_j_t))
  ) u_div_angle (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vi), .num(tiq.nj), .den(tiq.dj), .tag(tj_in),
    .out_valid(vj), .quo(qj), .out_tag(tjq)
  );

  // Stage 6: cosine and sine lookup.
  logic v6;
  tag_j_t t6;
  logic [14:0] c6, s6;
  logic [QJ-1:0] jj;

  assign jj = (qj > QJ'(COS_TABLE_DEPTH)) ? QJ'(COS_TABLE_DEPTH) : qj;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vj;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t6 <= tjq;
      c6 <= cos_rom[jj];
      s6 <= cos_rom[QJ'(COS_TABLE_DEPTH) - jj];
    end
  end

  // Stage 7: tangent ratio dividend and saturation limit.
  logic v7;
  tag_j_t t7;
  logic [27:0] nu7, lim7;
  logic [14:0] c7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t7 <= t6;
      nu7 <= 28'(s6) * INV_2SQRT3_Q14 + 28'(c6 >> 1);
      lim7 <= 28'(c6) * 28'd8193;
      c7 <= c6;
    end
  end

  // Stage 8: saturation decision.
  logic v8;
  tag_u_t t8;
  logic [27:0] nu8;
  logic [14:0] c8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t8 <= '{kind: t7.kind, sec: t7.sec, neg: t7.neg, inten: t7.inten, sat: nu7 >= lim7};
      nu8 <= (nu7 >= lim7) ? '0 : nu7;
      c8 <= c7;
    end
  end

  logic vu;
  logic [13:0] qu;
  tag_u_t tuq;

  spc_div_pipe #(
    .NW(28), .DW(15), .QW(14), .TW($bits(tag_u_t))
  ) u_div_ratio (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v8), .num(nu8), .den(c8), .tag(t8),
    .out_valid(vu), .quo(qu), .out_tag(tuq)
  );

  // Stage 9: sector components and their larger one.
  logic v9;
  tag_v_t t9;
  logic [14:0] mx9;
  logic [13:0] mn9;
  logic [13:0] uu;
  logic [14:0] first_c, second_c;
  logic fb_c;

  always_comb begin
    uu = tuq.sat ? 14'(Q14_HALF) : qu;
    first_c = tuq.neg ? Q14_HALF - 15'(uu) : Q14_HALF + 15'(uu);
    second_c = Q14_ONE - first_c;
    fb_c = first_c > second_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= vu;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t9 <= '{kind: tuq.kind, sec: tuq.sec, fb: fb_c, inten: tuq.inten};
      mx9 <= fb_c ? first_c : second_c;
      mn9 <= fb_c ? 14'(second_c) : 14'(first_c);
    end
  end

  // Stage 10: dividend for scaling the smaller component.
  logic v10;
  tag_v_t t10;
  logic [28:0] nv10;
  logic [14:0] mx10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t10 <= t9;
      nv10 <= 29'(mn9) * 29'(t9.inten) + 29'(mx9 >> 1);
      mx10 <= mx9;
    end
  end

  logic vv;
  logic [14:0] qv;
  tag_v_t tvq;

  spc_div_pipe #(
    .NW(29), .DW(15), .QW(15), .TW($bits(tag_v_t))
  ) u_div_scale (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v10), .num(nv10), .den(mx10), .tag(t10),
    .out_valid(vv), .quo(qv), .out_tag(tvq)
  );

  // Stage 11: clamp and scale to bytes.
  logic v11;
  tag_v_t t11;
  logic [22:0] pmax11, pmin11;
  logic [14:0] vmax, vmin;

  assign vmax = (tvq.inten > Q14_ONE) ? Q14_ONE : tvq.inten;
  assign vmin = (qv > Q14_ONE) ? Q14_ONE : qv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (en) begin
      v11 <= vv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t11 <= tvq;
      pmax11 <= 23'(vmax) * 23'd255 + 23'(Q14_HALF);
      pmin11 <= 23'(vmin) * 23'd255 + 23'(Q14_HALF);
    end
  end

  // Stage 12: output register.
  kind_t k12;
  logic [7:0] c0, c1;
  logic [7:0] r_c, g_c, b_c;

  assign c0 = t11.fb ? pmax11[21:14] : pmin11[21:14];
  assign c1 = t11.fb ? pmin11[21:14] : pmax11[21:14];

  always_comb begin
    r_c = 8'd0;
    g_c = 8'd0;
    b_c = 8'd0;
    unique case (t11.kind)
      KIND_BLACK: begin
      end
      KIND_WHITE: begin
        r_c = 8'd255;
        g_c = 8'd255;
        b_c = 8'd255;
      end
      KIND_THREE: begin
        r_c = 8'd255;
        g_c = 8'd51;
        b_c = 8'd51;
      end
      KIND_NORMAL: begin
        case (t11.sec)
          SEC_RG: begin
            r_c = c0;
            g_c = c1;
          end
          SEC_GB: begin
            g_c = c0;
            b_c = c1;
          end
          default: begin
            b_c = c0;
            r_c = c1;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (en) begin
      rgb_valid <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k12 <= t11.kind;
      red <= r_c;
      green <= g_c;
      blue <= b_c;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color_stall |=> v1)
    else $error("Accepted transfer did not enter the pipeline.");

  a_full_saturation: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && k12 == KIND_NORMAL |-> red == 8'd0 || green == 8'd0 || blue == 8'd0)
    else $error("Palette color has no zero component.");

  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> rgb_valid && $stable(k12))
    else $error("Pipeline moved while the output was held.");
`endif

endmodule
